@@ rtl/seglcd_pkg.sv @@
// Shared types, codes and constant tables for the segment LCD frame writer.
// Holds the command and result item structs, the font ROM and the segment maps.
// No dependencies.
package seglcd_pkg;

  // Frame geometry: three words of 52 segment bits, held as one flat vector.
  localparam int FrameWordBits = 52;
  localparam int FrameWords    = 3;
  localparam int FrameBits     = FrameWordBits * FrameWords;
  localparam int SegIdxW       = $clog2(FrameBits);

  // Character and icon ranges.
  localparam int FontFirst     = 'h20;
  localparam int FontLast      = 'h7E;
  localparam int FontDepth     = FontLast - FontFirst + 1;
  localparam int FontIdxW      = $clog2(FontDepth);
  localparam int NumPositions  = 8;
  localparam int PosIdxW       = $clog2(NumPositions);
  localparam int SegsPerChar   = 14;
  localparam int NumIcons      = 29;
  localparam int IconIdxW      = 5;

  // Command modes.
  typedef enum logic [1:0] {
    MODE_PUT_CHAR = 2'd0,
    MODE_SET_ICON = 2'd1,
    MODE_CLEAR    = 2'd2,
    MODE_STANDBY  = 2'd3
  } mode_t;

  // Result status codes.
  localparam logic STATUS_APPLIED  = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // One command item.
  typedef struct packed {
    mode_t                 mode;
    logic [7:0]            char_code;
    logic [7:0]            position;
    logic [IconIdxW-1:0]   symbol_index;
    logic                  enable;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic                     status;
    logic [FrameWordBits-1:0] frame_word0;
    logic [FrameWordBits-1:0] frame_word1;
    logic [FrameWordBits-1:0] frame_word2;
    logic                     standby_on;
  } result_t;

  typedef logic [SegIdxW-1:0]     seg_idx_t;
  typedef logic [SegsPerChar-1:0] glyph_t;

  // Flat frame bit index of a segment given as word number and bit number.
  function automatic seg_idx_t seg_at(input int word, input int bit_num);
    return SegIdxW'(word * FrameWordBits + bit_num);
  endfunction

  // Per-position segment scatter: entry i receives glyph bit i (a, b, ... m).
  localparam seg_idx_t PosMap [NumPositions][SegsPerChar] = '{
    '{seg_at(0,7),  seg_at(0,14), seg_at(0,13), seg_at(0,12), seg_at(0,0),
      seg_at(0,3),  seg_at(0,1),  seg_at(0,9),  seg_at(0,2),  seg_at(0,6),
      seg_at(0,10), seg_at(0,4),  seg_at(0,5),  seg_at(0,8)},
    '{seg_at(0,23), seg_at(0,30), seg_at(0,29), seg_at(0,28), seg_at(0,16),
      seg_at(0,19), seg_at(0,17), seg_at(0,25), seg_at(0,18), seg_at(0,22),
      seg_at(0,26), seg_at(0,20), seg_at(0,21), seg_at(0,24)},
    '{seg_at(0,39), seg_at(0,46), seg_at(0,45), seg_at(0,44), seg_at(0,32),
      seg_at(0,35), seg_at(0,33), seg_at(0,41), seg_at(0,34), seg_at(0,38),
      seg_at(0,42), seg_at(0,36), seg_at(0,37), seg_at(0,40)},
    '{seg_at(2,3),  seg_at(2,10), seg_at(2,9),  seg_at(2,8),  seg_at(0,48),
      seg_at(0,51), seg_at(0,49), seg_at(2,5),  seg_at(0,50), seg_at(2,2),
      seg_at(2,6),  seg_at(2,0),  seg_at(2,1),  seg_at(2,4)},
    '{seg_at(2,51), seg_at(1,2),  seg_at(1,1),  seg_at(1,0),  seg_at(2,44),
      seg_at(2,47), seg_at(2,45), seg_at(2,17), seg_at(2,46), seg_at(2,50),
      seg_at(2,18), seg_at(2,48), seg_at(2,49), seg_at(2,16)},
    '{seg_at(1,11), seg_at(1,14), seg_at(1,13), seg_at(1,12), seg_at(1,4),
      seg_at(1,7),  seg_at(1,5),  seg_at(2,21), seg_at(1,6),  seg_at(1,10),
      seg_at(2,22), seg_at(1,8),  seg_at(1,9),  seg_at(2,20)},
    '{seg_at(1,23), seg_at(1,26), seg_at(1,25), seg_at(1,24), seg_at(1,16),
      seg_at(1,19), seg_at(1,17), seg_at(2,25), seg_at(1,18), seg_at(1,22),
      seg_at(2,26), seg_at(1,20), seg_at(1,21), seg_at(2,24)},
    '{seg_at(1,35), seg_at(2,34), seg_at(2,33), seg_at(2,32), seg_at(1,28),
      seg_at(1,31), seg_at(1,29), seg_at(2,29), seg_at(1,30), seg_at(1,34),
      seg_at(2,30), seg_at(1,32), seg_at(1,33), seg_at(2,28)}
  };

  // Frame bit of each icon segment.
  localparam seg_idx_t IconMap [NumIcons] = '{
    seg_at(0,11), seg_at(0,15), seg_at(0,27), seg_at(0,31), seg_at(0,43),
    seg_at(0,47), seg_at(2,7),  seg_at(2,11), seg_at(2,15), seg_at(2,19),
    seg_at(2,23), seg_at(2,31), seg_at(2,27), seg_at(2,35), seg_at(2,37),
    seg_at(2,38), seg_at(2,36), seg_at(2,39), seg_at(2,40), seg_at(2,43),
    seg_at(1,3),  seg_at(1,15), seg_at(1,27), seg_at(1,36), seg_at(1,39),
    seg_at(1,37), seg_at(1,38), seg_at(2,13), seg_at(2,14)
  };

  // 14-segment font for printable codes, first entry is the space character.
  localparam glyph_t FontRom [FontDepth] = '{
    14'h0000, 14'h0000, 14'h0220, 14'h0000, 14'h12ED, 14'h2DE4, 14'h2B0D, 14'h0200,
    14'h2400, 14'h0900, 14'h3FC0, 14'h12C0, 14'h0800, 14'h00C0, 14'h0000, 14'h0C00,
    14'h0C3F, 14'h0006, 14'h00DB, 14'h00CF, 14'h00E6, 14'h00ED, 14'h00FD, 14'h0027,
    14'h00FF, 14'h00EF, 14'h0000, 14'h0000, 14'h0C08, 14'h00C8, 14'h2108, 14'h10A3,
    14'h10BF, 14'h00F7, 14'h128F, 14'h0039, 14'h120F, 14'h00F9, 14'h00F1, 14'h00BD,
    14'h00F6, 14'h1209, 14'h001E, 14'h3680, 14'h0038, 14'h1536, 14'h2136, 14'h003F,
    14'h00F3, 14'h203F, 14'h20F3, 14'h21ED, 14'h1201, 14'h003E, 14'h0C30, 14'h2A36,
    14'h2D00, 14'h1500, 14'h0C09, 14'h0000, 14'h2100, 14'h0000, 14'h0120, 14'h0008,
    14'h0100, 14'h00F7, 14'h12CF, 14'h0039, 14'h120F, 14'h00F9, 14'h00F1, 14'h00BD,
    14'h00F6, 14'h1209, 14'h001E, 14'h3680, 14'h0038, 14'h1536, 14'h2136, 14'h003F,
    14'h00F3, 14'h203F, 14'h20F3, 14'h21ED, 14'h1201, 14'h003E, 14'h0C30, 14'h2A36,
    14'h2D00, 14'h1500, 14'h0C09, 14'h0000, 14'h1200, 14'h0000, 14'h3FFF
  };

endpackage

@@ rtl/seglcd_frame_update.sv @@
// Next-state logic of the segment frame for one command item.
// Decodes the command, looks up the glyph and scatters it into the frame.
// Depends on seglcd_pkg.
module seglcd_frame_update (
  input  seglcd_pkg::cmd_t                       cmd,
  input  logic [seglcd_pkg::FrameBits-1:0]       frame,
  input  logic                                   standby,
  output logic [seglcd_pkg::FrameBits-1:0]       frame_nxt,
  output logic                                   standby_nxt,
  output logic                                   status
);

  logic [7:0]                        code_ofs;
  logic [seglcd_pkg::FontIdxW-1:0]   font_idx;
  logic [seglcd_pkg::PosIdxW-1:0]    pos_idx;
  logic                              char_ok;
  logic                              pos_ok;
  logic                              icon_ok;

  // Range checks and table indexes.
  assign code_ofs = cmd.char_code - 8'(seglcd_pkg::FontFirst);
  assign font_idx = code_ofs[seglcd_pkg::FontIdxW-1:0];
  assign pos_idx  = cmd.position[seglcd_pkg::PosIdxW-1:0];
  assign char_ok  = (cmd.char_code >= 8'(seglcd_pkg::FontFirst)) &&
                    (cmd.char_code <= 8'(seglcd_pkg::FontLast));
  assign pos_ok   = cmd.position < 8'(seglcd_pkg::NumPositions);
  assign icon_ok  = cmd.symbol_index < seglcd_pkg::IconIdxW'(seglcd_pkg::NumIcons);

  // Apply the command to the frame and standby flag.
  always_comb begin
    seglcd_pkg::glyph_t glyph;
    glyph       = '0;
    frame_nxt   = frame;
    standby_nxt = standby;
    status      = seglcd_pkg::STATUS_APPLIED;
    unique case (cmd.mode)
      seglcd_pkg::MODE_PUT_CHAR: begin
        if (char_ok && pos_ok) begin
          glyph = seglcd_pkg::FontRom[font_idx];
          for (int i = 0; i < seglcd_pkg::SegsPerChar; i++) begin
            frame_nxt[seglcd_pkg::PosMap[pos_idx][i]] = glyph[i];
          end
        end else begin
          status = seglcd_pkg::STATUS_REJECTED;
        end
      end
      seglcd_pkg::MODE_SET_ICON: begin
        if (icon_ok) begin
          frame_nxt[seglcd_pkg::IconMap[cmd.symbol_index]] = cmd.enable;
        end else begin
          status = seglcd_pkg::STATUS_REJECTED;
        end
      end
      seglcd_pkg::MODE_CLEAR: begin
        frame_nxt = '0;
      end
      seglcd_pkg::MODE_STANDBY: begin
        standby_nxt = cmd.enable;
      end
      default: begin
        status = seglcd_pkg::STATUS_REJECTED;
      end
    endcase
  end

endmodule

@@ rtl/segment_lcd_frame_writer.sv @@
// Top level of the segment LCD frame writer: input register, frame state
// and result register around the frame update logic.
// Depends on seglcd_pkg and seglcd_frame_update.
//
// Usage:
//   The in_ channel takes command items (put a character at a digit
//   position, set or clear an icon, clear the frame, set standby). The out_
//   channel returns one result item per command: a status (applied or
//   rejected as out of range), the three 52-bit frame words after the item
//   and the standby flag. An item is moved when valid is high and stall low.
//   The result is registered: the input register holds the command until
//   the result register is free, and the result register then takes the
//   result. The frame update is a single pass of glyph lookup and bit
//   scatter between these registers, so one item is accepted every cycle
//   while the receiver does not stall, and each item sees the frame left
//   by the item before it.
//   When the receiver stalls, the result register holds its item and the
//   input register holds the next one; in_stall rises only while both are
//   full. Reset (synchronous, active low) clears the frame to all segments
//   off, clears standby and empties both registers.
module segment_lcd_frame_writer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  seglcd_pkg::cmd_t      in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output seglcd_pkg::result_t   out_data
);

  localparam int W = seglcd_pkg::FrameWordBits;

  logic                                 cmd_valid_r, cmd_valid_nxt;
  seglcd_pkg::cmd_t                     cmd_r;
  logic                                 out_valid_r, out_valid_nxt;
  seglcd_pkg::result_t                  out_r, out_nxt;
  logic [seglcd_pkg::FrameBits-1:0]     frame_r, frame_nxt;
  logic                                 standby_r, standby_nxt;
  logic                                 status;
  logic                                 in_accept;
  logic                                 advance;

  // Handshake: the held item moves on whenever the result register is free.
  assign advance       = cmd_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = cmd_valid_r && !advance;
  assign in_accept     = in_valid && !in_stall;
  assign cmd_valid_nxt = in_accept || (cmd_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  // Frame update for the held item.
  seglcd_frame_update u_update (
    .cmd         (cmd_r),
    .frame       (frame_r),
    .standby     (standby_r),
    .frame_nxt   (frame_nxt),
    .standby_nxt (standby_nxt),
    .status      (status)
  );

  // Result item built from the updated state.
  always_comb begin
    out_nxt.status      = status;
    out_nxt.frame_word0 = frame_nxt[W-1:0];
    out_nxt.frame_word1 = frame_nxt[2*W-1:W];
    out_nxt.frame_word2 = frame_nxt[3*W-1:2*W];
    out_nxt.standby_on  = standby_nxt;
  end

  // Control state and frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      frame_r     <= '0;
      standby_r   <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        frame_r   <= frame_nxt;
        standby_r <= standby_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/seglcd_checker.sv @@
// Port-level checks for the segment LCD frame writer, bound to the top level.
// Depends on seglcd_pkg and segment_lcd_frame_writer.
module seglcd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input seglcd_pkg::result_t  out_data
);

  // Reset empties the block: no result and room for an item.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // Input backpressure only comes from a stalled, full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind segment_lcd_frame_writer seglcd_checker u_checker (.*);
